// ===== hdl/hete_pkg.sv =====
// Package for the heading error block: widths, angle constants, CORDIC angle table
// and the pipeline beat type shared by all stages.
// No dependencies.
`default_nettype none

package hete_pkg;

  // Field and internal widths
  localparam int CoordW  = 16;               // Q4.12 coordinate
  localparam int AngW    = 16;               // rad * 8192 on the ports
  localparam int XW      = 20;               // CORDIC vector, covers gain on 17-bit deltas
  localparam int ZW      = 17;               // CORDIC angle accumulator
  localparam int EW      = 18;               // bearing minus heading before wrap

  localparam int CordicStepsDef = 16;
  localparam int AtanLen        = 24;

  typedef logic signed [ZW-1:0] ang_t;

  localparam ang_t AngPi     = ang_t'(25736);
  localparam ang_t AngHalfPi = ang_t'(12868);

  // atan(2^-i) * 8192, rounded to nearest
  localparam ang_t AtanTab [AtanLen] = '{
    ang_t'(6434), ang_t'(3798), ang_t'(2007), ang_t'(1019),
    ang_t'(511),  ang_t'(256),  ang_t'(128),  ang_t'(64),
    ang_t'(32),   ang_t'(16),   ang_t'(8),    ang_t'(4),
    ang_t'(2),    ang_t'(1),    ang_t'(0),    ang_t'(0),
    ang_t'(0),    ang_t'(0),    ang_t'(0),    ang_t'(0),
    ang_t'(0),    ang_t'(0),    ang_t'(0),    ang_t'(0)
  };

  // One beat in flight through the CORDIC stages
  typedef struct packed {
    logic signed [XW-1:0]     x;
    logic signed [XW-1:0]     y;
    ang_t                     z;
    logic                     hold;     // axis or coincident case, z already final
    logic signed [AngW-1:0]   heading;
  } cordic_t;

endpackage

`default_nettype wire

// ===== hdl/hete_prep.sv =====
// Front stage: target minus pose deltas, axis detection, left half plane prerotation.
// Depends on hete_pkg.
`default_nettype none

module hete_prep import hete_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [CoordW-1:0]  cur_x,
  input  wire logic signed [CoordW-1:0]  cur_y,
  input  wire logic signed [AngW-1:0]    cur_heading,
  input  wire logic signed [CoordW-1:0]  tar_x,
  input  wire logic signed [CoordW-1:0]  tar_y,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output cordic_t                        out_data
);

  logic signed [XW-1:0] dx, dy;
  cordic_t              data_next;
  cordic_t              data;
  logic                 valid;

  // deltas, exact in XW bits
  assign dx = XW'(tar_x) - XW'(cur_x);
  assign dy = XW'(tar_y) - XW'(cur_y);

  // start vector and angle
  always_comb begin
    data_next         = '0;
    data_next.heading = cur_heading;
    if (dx == '0 && dy == '0) begin
      data_next.hold = 1'b1;
      data_next.z    = '0;
    end else if (dx == '0) begin
      data_next.hold = 1'b1;
      data_next.z    = (dy > 0) ? AngHalfPi : -AngHalfPi;
    end else if (dy == '0) begin
      data_next.hold = 1'b1;
      data_next.z    = (dx > 0) ? ang_t'(0) : AngPi;
    end else if (dx < 0) begin
      if (dy > 0) begin
        data_next.x = dy;
        data_next.y = -dx;
        data_next.z = AngHalfPi;
      end else begin
        data_next.x = -dy;
        data_next.y = dx;
        data_next.z = -AngHalfPi;
      end
    end else begin
      data_next.x = dx;
      data_next.y = dy;
      data_next.z = '0;
    end
  end

  assign in_ready = !valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

// ===== hdl/hete_cstage.sv =====
// One CORDIC vectoring iteration with its own stage register.
// Depends on hete_pkg.
`default_nettype none

module hete_cstage import hete_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire cordic_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cordic_t      out_data
);

  localparam ang_t Ang = AtanTab[STEP];

  logic signed [XW-1:0] xs, ys;
  cordic_t              data_next;
  cordic_t              data;
  logic                 valid;

  // floor shifts
  assign xs = in_data.x >>> STEP;
  assign ys = in_data.y >>> STEP;

  // rotate toward the x axis; held beats pass unchanged
  always_comb begin
    data_next = in_data;
    if (!in_data.hold) begin
      if (in_data.y >= 0) begin
        data_next.x = in_data.x + ys;
        data_next.y = in_data.y - xs;
        data_next.z = in_data.z + Ang;
      end else begin
        data_next.x = in_data.x - ys;
        data_next.y = in_data.y + xs;
        data_next.z = in_data.z - Ang;
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

// ===== hdl/hete_wrap.sv =====
// Back stage: bearing saturation, heading subtraction and single wrap into +-pi.
// Depends on hete_pkg.
`default_nettype none

module hete_wrap import hete_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire cordic_t                 in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [AngW-1:0]       heading_error
);

  localparam logic signed [EW-1:0] PiE    = EW'(AngPi);
  localparam logic signed [EW-1:0] TwoPiE = EW'(AngPi) + EW'(AngPi);

  ang_t                  bearing;
  logic signed [EW-1:0]  diff;
  logic signed [EW-1:0]  err_next;
  logic signed [AngW-1:0] err;
  logic                  valid;

  // saturate CORDIC overshoot
  always_comb begin
    if (in_data.z > AngPi) begin
      bearing = AngPi;
    end else if (in_data.z < -AngPi) begin
      bearing = -AngPi;
    end else begin
      bearing = in_data.z;
    end
  end

  // difference and one wrap step
  assign diff = EW'(bearing) - EW'(in_data.heading);

  always_comb begin
    if (diff > PiE) begin
      err_next = diff - TwoPiE;
    end else if (diff < -PiE) begin
      err_next = diff + TwoPiE;
    end else begin
      err_next = diff;
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      err <= err_next[AngW-1:0];
    end
  end

  assign out_valid     = valid;
  assign heading_error = err;

endmodule

`default_nettype wire

// ===== hdl/heading_error_to_target.sv =====
// Top level of the heading error block: prep stage, CORDIC stage chain, wrap stage.
// Depends on hete_pkg, hete_prep, hete_cstage, hete_wrap.
//
//  channel  | signals                                        | dir
//  ---------+------------------------------------------------+-----
//  input    | in_valid, in_ready, cur_x, cur_y, cur_heading, | in
//           | tar_x, tar_y                                   |
//  output   | out_valid, out_ready, heading_error            | out
//
// One beat enters per cycle unless out_ready stalls a full chain; the pipeline is the
// prep stage, one stage per CORDIC iteration and the wrap stage, CORDIC_STEPS capped at 24.
// Each stage has its own valid bit; ready runs back through the chain so an empty
// stage fills even while the output beat waits.
// Synchronous reset clears all valid bits; data registers are not reset.
`default_nettype none

module heading_error_to_target import hete_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [CoordW-1:0]  cur_x,
  input  wire logic signed [CoordW-1:0]  cur_y,
  input  wire logic signed [AngW-1:0]    cur_heading,
  input  wire logic signed [CoordW-1:0]  tar_x,
  input  wire logic signed [CoordW-1:0]  tar_y,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [AngW-1:0]         heading_error
);

  localparam int NSteps = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;

  logic    c_valid [NSteps+1];
  logic    c_ready [NSteps+1];
  cordic_t c_data  [NSteps+1];

  // front stage
  hete_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cur_x       (cur_x),
    .cur_y       (cur_y),
    .cur_heading (cur_heading),
    .tar_x       (tar_x),
    .tar_y       (tar_y),
    .out_valid   (c_valid[0]),
    .out_ready   (c_ready[0]),
    .out_data    (c_data[0])
  );

  // CORDIC iterations
  for (genvar k = 0; k < NSteps; k++) begin : g_step
    hete_cstage #(.STEP(k)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .in_data   (c_data[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .out_data  (c_data[k+1])
    );
  end

  // back stage
  hete_wrap u_wrap (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (c_valid[NSteps]),
    .in_ready      (c_ready[NSteps]),
    .in_data       (c_data[NSteps]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .heading_error (heading_error)
  );

  // result always lands within +-pi
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_error <= AngW'(AngPi) && heading_error >= -AngW'(AngPi)))
    else $error("heading_error outside +-pi");

  // an empty output stage means the whole chain can take a beat
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // axis cases leave the chain with an exact axis angle
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (c_valid[NSteps] && c_data[NSteps].hold) |->
      (c_data[NSteps].z == '0 || c_data[NSteps].z == AngHalfPi ||
       c_data[NSteps].z == -AngHalfPi || c_data[NSteps].z == AngPi))
    else $error("held beat lost its axis angle");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for heading_error_to_target: random and corner-case poses,
// results checked against an in-bench CORDIC atan2 predictor.
// Depends on hete_pkg and the heading_error_to_target RTL.
`default_nettype none

module testbench import hete_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Angle unit is rad * 8192
  localparam int PiAng     = 25736;
  localparam int HalfPiAng = 12868;
  localparam int Steps     = CordicStepsDef;
  localparam int RotSteps  = (Steps > 24) ? 24 : Steps;
  localparam int Latency   = RotSteps + 2;
  localparam int MaxPrints = 40;

  // atan(2^-i) in angle units, rounded to nearest
  localparam int ArcTab [24] = '{
    6434, 3798, 2007, 1019, 511, 256, 128, 64,
    32, 16, 8, 4, 2, 1, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [AngW-1:0]   hd;
    logic signed [CoordW-1:0] tx;
    logic signed [CoordW-1:0] ty;
  } pose_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CoordW-1:0] cur_x = '0;
  logic signed [CoordW-1:0] cur_y = '0;
  logic signed [AngW-1:0]   cur_heading = '0;
  logic signed [CoordW-1:0] tar_x = '0;
  logic signed [CoordW-1:0] tar_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [AngW-1:0]   heading_error;

  pose_t                  pose_q[$];
  logic signed [AngW-1:0] err_exp_q[$];
  int  n_queued   = 0;
  int  n_accepted = 0;
  int  n_checked  = 0;
  int  n_errors   = 0;
  int  n_directed = 0;
  bit  idling_on  = 1'b1;
  bit  in_taken   = 1'b0;

  heading_error_to_target #(.CORDIC_STEPS(Steps)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cur_x         (cur_x),
    .cur_y         (cur_y),
    .cur_heading   (cur_heading),
    .tar_x         (tar_x),
    .tar_y         (tar_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .heading_error (heading_error)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Bearing to target by CORDIC vectoring, minus heading, wrapped once
  function automatic logic signed [AngW-1:0] predict_heading_err(pose_t p);
    longint dx, dy, x, y, z, xn, yn, err;
    dx = longint'(p.tx) - longint'(p.cx);
    dy = longint'(p.ty) - longint'(p.cy);
    if (dx == 0 && dy == 0) begin
      z = 0;
    end else if (dx == 0) begin
      z = (dy > 0) ? HalfPiAng : -HalfPiAng;
    end else if (dy == 0) begin
      z = (dx > 0) ? 0 : PiAng;
    end else begin
      // left half plane: pre-rotate by a quarter turn
      if (dx < 0 && dy > 0) begin
        x = dy;  y = -dx; z = HalfPiAng;
      end else if (dx < 0) begin
        x = -dy; y = dx;  z = -HalfPiAng;
      end else begin
        x = dx;  y = dy;  z = 0;
      end
      for (int i = 0; i < RotSteps; i++) begin
        if (y >= 0) begin
          xn = x + (y >>> i);
          yn = y - (x >>> i);
          z  = z + ArcTab[i];
        end else begin
          xn = x - (y >>> i);
          yn = y + (x >>> i);
          z  = z - ArcTab[i];
        end
        x = xn;
        y = yn;
      end
      // CORDIC overshoot past +-pi saturates
      if (z > PiAng) z = PiAng;
      if (z < -PiAng) z = -PiAng;
    end
    err = z - longint'(p.hd);
    if (err > PiAng) err = err - 2 * PiAng;
    else if (err < -PiAng) err = err + 2 * PiAng;
    return AngW'(err);
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p.cx = CoordW'($urandom);
    p.cy = CoordW'($urandom);
    p.tx = CoordW'($urandom);
    p.ty = CoordW'($urandom);
    p.hd = AngW'(int'($urandom_range(0, 2 * PiAng)) - PiAng);
    case (kind)
      4, 5: begin
        // short range to target
        p.tx = p.cx + CoordW'(int'($urandom_range(0, 1000)) - 500);
        p.ty = p.cy + CoordW'(int'($urandom_range(0, 1000)) - 500);
      end
      6: begin
        // vertical axis, sometimes coincident
        p.tx = p.cx;
        if ($urandom_range(0, 3) == 0) p.ty = p.cy;
      end
      7: p.ty = p.cy;
      8: begin
        // close to the negative x axis, where the bearing can overshoot pi
        p.cx = CoordW'(int'($urandom_range(0, 30000)));
        p.tx = CoordW'(-int'($urandom_range(0, 32768)));
        p.ty = p.cy + CoordW'(int'($urandom_range(0, 6)) - 3);
      end
      9: p.hd = AngW'($urandom);  // heading may lie beyond +-pi
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_pose(int cx, int cy, int hd, int tx, int ty);
    pose_t p;
    p.cx = CoordW'(cx);
    p.cy = CoordW'(cy);
    p.hd = AngW'(hd);
    p.tx = CoordW'(tx);
    p.ty = CoordW'(ty);
    pose_q.push_back(p);
    n_queued++;
  endtask

  task automatic add_random(int count);
    repeat (count) begin
      pose_q.push_back(random_pose());
      n_queued++;
    end
  endtask

  task automatic wait_drained();
    wait (n_accepted == n_queued && err_exp_q.size() == 0);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (n_errors < MaxPrints)
      $display("%0t ns: MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  // Sender: one beat at a time, held until taken, random idle bursts
  always @(negedge clk) begin
    int gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pose_q.size() > 0) begin
        pose_t p;
        p = pose_q.pop_front();
        cur_x       <= p.cx;
        cur_y       <= p.cy;
        cur_heading <= p.hd;
        tar_x       <= p.tx;
        tar_y       <= p.ty;
        in_valid    <= 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off that backs up the pipe
  always @(negedge clk) begin
    int stall_left;
    int hold_left;
    bit hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (!hold_done && n_accepted >= 300) begin
        hold_left = 250;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // Monitor: check output beats first, then record the input beat taken
  always @(posedge clk) begin
    logic signed [AngW-1:0] want;
    in_taken <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (err_exp_q.size() == 0) begin
          report_mismatch("unexpected heading_error beat", heading_error, 0);
        end else begin
          want = err_exp_q.pop_front();
          if (heading_error !== want)
            report_mismatch("heading_error", heading_error, want);
          n_checked++;
        end
      end
      if (in_valid && in_ready) begin
        pose_t p;
        p.cx = cur_x;
        p.cy = cur_y;
        p.hd = cur_heading;
        p.tx = tar_x;
        p.ty = tar_y;
        err_exp_q.push_back(predict_heading_err(p));
        n_accepted++;
      end
    end
  end

  // Run limit
  initial begin
    #5ms;
    $display("%0t ns: timeout, %0d results still pending", $time, err_exp_q.size());
    $display("testbench: errors");
    $finish;
  end

  // Stimulus phases
  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners: coincident points, the four axis bearings,
    // both left-half-plane pre-rotations, overshoot near pi, wrap both ways,
    // headings beyond pi, coordinate extremes
    add_pose(0, 0, 0, 0, 0);
    add_pose(-32768, 32767, -32768, -32768, 32767);
    add_pose(100, 100, 0, 100, 5000);
    add_pose(100, 100, 0, 100, -5000);
    add_pose(-300, 7, 1000, 9000, 7);
    add_pose(300, 7, -PiAng, -9000, 7);
    add_pose(300, 7, PiAng, -9000, 7);
    add_pose(0, 0, 0, -100, 1);
    add_pose(0, 0, 0, -100, -1);
    add_pose(32767, 0, 0, -32768, 1);
    add_pose(32767, 0, 0, -32768, -1);
    add_pose(0, 0, -24000, -20000, 2000);
    add_pose(0, 0, 24000, -20000, -2000);
    add_pose(0, 0, 32767, 1000, 1000);
    add_pose(0, 0, -32768, -1000, -1000);
    add_pose(0, 0, 32767, -1000, 10);
    add_pose(-32768, -32768, 0, 32767, 32767);
    add_pose(32767, 32767, 0, -32768, -32768);
    add_pose(32767, -32768, PiAng, -32768, 32767);
    add_pose(-32768, 32767, -PiAng, 32767, -32768);
    add_pose(0, 0, 0, 1, 1);
    add_pose(0, 0, 0, 32767, -1);
    n_directed = n_queued;
    wait_drained();

    // Random with idling on both sides; the long output hold-off lands here
    add_random(500);
    wait_drained();
    add_random(500);
    wait_drained();

    // Full rate, no idling
    idling_on = 1'b0;
    add_random(200);
    wait_drained();
    repeat (Latency + 8) @(posedge clk);

    $display("summary: %0d poses (%0d directed corners) sent, %0d results checked, %0d bad",
             n_accepted, n_directed, n_checked, n_errors);
    $display("summary: idle/stall bursts, one long output hold-off, full-rate tail");
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== heading_error_to_target.f =====
hdl/hete_pkg.sv
hdl/hete_prep.sv
hdl/hete_cstage.sv
hdl/hete_wrap.sv
hdl/heading_error_to_target.sv
verif/testbench.sv
